@@ rtl/imu_swo_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package imu_swo_pkg;

  // Default window depth in samples.
  localparam int WINDOW_DEFAULT = 50;

  // Field widths fixed by the sample format.
  localparam int ACC_W  = 16;
  localparam int GYR_W  = 8;
  localparam int DATA_W = 3 * ACC_W + 3 * GYR_W;
  localparam int LANES  = 6;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_SLIDING = 1'b0;
  localparam logic REG_SPREAD  = 1'b1;
  localparam logic [7:0] SPREAD_RESET = 8'd20;

  // Gyro sum adjustment before the mean is taken.
  localparam int GYRO_ADJ_THRESHOLD = -45;
  localparam int GYRO_ADJ_AMOUNT    = 5;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [GYR_W-1:0] gyr_t;

  // Six axes packed with accel x in the lowest bits.
  typedef struct packed {
    gyr_t gz;
    gyr_t gy;
    gyr_t gx;
    acc_t az;
    acc_t ay;
    acc_t ax;
  } axes_t;

  // One queue word: a sample and whether it closes an evaluation.
  typedef struct packed {
    logic  eval;
    axes_t sample;
  } job_t;

endpackage

`default_nettype wire

@@ rtl/imu_swo_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module imu_swo_front #(
  parameter int WINDOW = imu_swo_pkg::WINDOW_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                sliding_mode,
  input  wire logic                s_valid,
  output logic                     s_ready,
  input  wire imu_swo_pkg::axes_t  s_sample,
  output logic                     q_valid,
  input  wire logic                q_ready,
  output imu_swo_pkg::job_t        q_job
);
  import imu_swo_pkg::*;

  localparam int CW = $clog2(WINDOW + 1);

  logic [CW-1:0] fill_count;
  logic [CW-1:0] fill_inc;
  logic [CW-1:0] fill_count_next;
  logic          eval_now;
  logic          accept;
  logic          pop;

  job_t          queue [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    level;

  // Classify the incoming word: does it complete a window evaluation?
  always_comb begin
    fill_inc = (fill_count < CW'(WINDOW)) ? CW'(fill_count + 1'b1) : fill_count;
    eval_now = (fill_inc == CW'(WINDOW));
    fill_count_next = (eval_now && !sliding_mode) ? '0 : fill_inc;
  end

  assign s_ready = (level != 2'd2);
  assign accept  = s_valid && s_ready;
  assign q_valid = (level != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_job   = queue[rd_ptr];

  // Fill counter and queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
      level      <= 2'd0;
    end else begin
      if (accept) begin
        fill_count <= fill_count_next;
        wr_ptr     <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (accept && !pop) begin
        level <= level + 2'd1;
      end else if (!accept && pop) begin
        level <= level - 2'd1;
      end
    end
  end

  // Two-word queue storage.
  always_ff @(posedge clk) begin
    if (accept) begin
      queue[wr_ptr] <= '{eval: eval_now, sample: s_sample};
    end
  end

endmodule

`default_nettype wire

@@ rtl/imu_swo_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module imu_swo_back #(
  parameter int WINDOW = imu_swo_pkg::WINDOW_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [7:0]          spread_limit,
  input  wire logic                q_valid,
  output logic                     q_ready,
  input  wire imu_swo_pkg::job_t   q_job,
  output logic                     m_valid,
  input  wire logic                m_ready,
  output logic                     m_still,
  output imu_swo_pkg::axes_t       m_offsets
);
  import imu_swo_pkg::*;

  localparam int AW     = $clog2(WINDOW);
  localparam int CW     = $clog2(WINDOW + 1);
  localparam int SUM_W  = ACC_W + 1 + $clog2(WINDOW);
  localparam int DC_W   = $clog2(LANES + 1);
  // Magnitudes of the adjusted sums always fit in one bit less than a lane.
  localparam int DVD_W  = SUM_W - 1;
  // Reciprocal of the window depth, scaled so that the quotient is exact
  // for every magnitude of DVD_W bits.
  localparam int REC_K  = DVD_W + AW;
  localparam int REC_W  = SUM_W + 1;
  localparam int PROD_W = DVD_W + REC_W;
  localparam logic [63:0] REC_FULL =
    ((64'd1 << REC_K) + 64'(WINDOW - 1)) / 64'(WINDOW);
  localparam logic [REC_W-1:0] RECIP = REC_FULL[REC_W-1:0];

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_CHECK = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                    state;
  logic [AW-1:0]             wptr;
  logic [CW-1:0]             cnt;
  logic                      rd_vld;
  logic                      first;
  logic                      still_r;
  logic [DC_W-1:0]           div_cnt;
  axes_t                     held;
  axes_t                     mem [WINDOW];
  axes_t                     rd_data;

  logic signed [SUM_W-1:0]   lane_v  [LANES];
  logic signed [SUM_W-1:0]   lo      [LANES];
  logic signed [SUM_W-1:0]   hi      [LANES];
  logic signed [SUM_W-1:0]   sum     [LANES];
  logic signed [SUM_W-1:0]   adj     [LANES];
  logic        [SUM_W-1:0]   diff    [LANES];
  logic        [SUM_W-1:0]   mag     [LANES];
  logic        [SUM_W-1:0]   dvd     [LANES];
  logic                      neg     [LANES];
  logic signed [SUM_W-1:0]   quo     [LANES];
  logic        [DC_W-1:0]    div_lane;
  logic        [DVD_W-1:0]   div_in;
  logic        [PROD_W-1:0]  div_prod;
  logic        [SUM_W-1:0]   div_quo;
  logic                      still_c;
  logic                      mem_re;
  logic                      pop;
  axes_t                     new_off;

  assign q_ready = (state == S_IDLE);
  assign pop     = q_valid && q_ready;
  assign mem_re  = (state == S_SCAN) && (cnt < CW'(WINDOW));

  // Sign-extend the six axes of the word just read into lane width.
  always_comb begin
    lane_v[0] = {{(SUM_W-ACC_W){rd_data.ax[ACC_W-1]}}, rd_data.ax};
    lane_v[1] = {{(SUM_W-ACC_W){rd_data.ay[ACC_W-1]}}, rd_data.ay};
    lane_v[2] = {{(SUM_W-ACC_W){rd_data.az[ACC_W-1]}}, rd_data.az};
    lane_v[3] = {{(SUM_W-GYR_W){rd_data.gx[GYR_W-1]}}, rd_data.gx};
    lane_v[4] = {{(SUM_W-GYR_W){rd_data.gy[GYR_W-1]}}, rd_data.gy};
    lane_v[5] = {{(SUM_W-GYR_W){rd_data.gz[GYR_W-1]}}, rd_data.gz};
  end

  // Spread test, gyro adjustment and magnitudes for the divider.
  always_comb begin
    still_c = 1'b1;
    for (int a = 0; a < LANES; a++) begin
      diff[a] = hi[a] - lo[a];
      if (diff[a] > SUM_W'(spread_limit)) begin
        still_c = 1'b0;
      end
      if (a >= 3 && sum[a] < GYRO_ADJ_THRESHOLD) begin
        adj[a] = sum[a] - SUM_W'(GYRO_ADJ_AMOUNT);
      end else begin
        adj[a] = sum[a];
      end
      mag[a] = adj[a][SUM_W-1] ? -adj[a] : adj[a];
    end
  end

  // One lane per cycle is divided by multiplying its magnitude with the
  // scaled reciprocal; the quotient is the top part of the product.
  always_comb begin
    div_lane = DC_W'(LANES) - div_cnt;
    div_in   = '0;
    for (int a = 0; a < LANES; a++) begin
      if (div_lane == DC_W'(a)) begin
        div_in = dvd[a][DVD_W-1:0];
      end
    end
    div_prod = PROD_W'(div_in) * PROD_W'(RECIP);
    div_quo  = SUM_W'(div_prod >> REC_K);
    for (int a = 0; a < LANES; a++) begin
      quo[a] = neg[a] ? -dvd[a] : dvd[a];
    end
  end

  // New offsets: quotients signed back, gyro means saturated to a byte.
  always_comb begin
    new_off    = '0;
    new_off.ax = quo[0][ACC_W-1:0];
    new_off.ay = quo[1][ACC_W-1:0];
    new_off.az = quo[2][ACC_W-1:0];
    for (int a = 3; a < LANES; a++) begin
      gyr_t g;
      if (quo[a] < -128) begin
        g = -8'sd128;
      end else if (quo[a] > 127) begin
        g = 8'sd127;
      end else begin
        g = quo[a][GYR_W-1:0];
      end
      case (a)
        3:       new_off.gx = g;
        4:       new_off.gy = g;
        default: new_off.gz = g;
      endcase
    end
  end

  // Window memory: one write from the queue, one registered read for the scan.
  always_ff @(posedge clk) begin
    if (pop) begin
      mem[wptr] <= q_job.sample;
    end
    if (mem_re) begin
      rd_data <= mem[cnt[AW-1:0]];
    end
  end

  // Sequencer and output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      wptr    <= '0;
      cnt     <= '0;
      rd_vld  <= 1'b0;
      first   <= 1'b0;
      still_r <= 1'b0;
      div_cnt <= '0;
      held    <= '0;
      m_valid <= 1'b0;
    end else begin
      rd_vld <= mem_re;
      if (m_valid && m_ready && state != S_DONE) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            wptr <= (wptr == AW'(WINDOW - 1)) ? '0 : AW'(wptr + 1'b1);
            if (q_job.eval) begin
              cnt   <= '0;
              first <= 1'b1;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (mem_re) begin
            cnt <= CW'(cnt + 1'b1);
          end
          if (rd_vld) begin
            first <= 1'b0;
          end
          if (cnt == CW'(WINDOW)) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          still_r <= still_c;
          div_cnt <= DC_W'(LANES);
          state   <= still_c ? S_DIV : S_DONE;
        end
        S_DIV: begin
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == DC_W'(1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_valid || m_ready) begin
            m_valid <= 1'b1;
            if (still_r) begin
              held <= new_off;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Lane accumulators, divider registers and result word.
  always_ff @(posedge clk) begin
    if (state == S_SCAN && rd_vld) begin
      for (int a = 0; a < LANES; a++) begin
        if (first || lane_v[a] < lo[a]) lo[a] <= lane_v[a];
        if (first || lane_v[a] > hi[a]) hi[a] <= lane_v[a];
        sum[a] <= first ? lane_v[a] : sum[a] + lane_v[a];
      end
    end
    if (state == S_CHECK) begin
      for (int a = 0; a < LANES; a++) begin
        dvd[a] <= mag[a];
        neg[a] <= adj[a][SUM_W-1];
      end
    end
    if (state == S_DIV) begin
      for (int a = 0; a < LANES; a++) begin
        if (div_lane == DC_W'(a)) begin
          dvd[a] <= div_quo;
        end
      end
    end
    if (state == S_DONE && (!m_valid || m_ready)) begin
      m_still   <= still_r;
      m_offsets <= still_r ? new_off : held;
    end
  end

endmodule

`default_nettype wire

@@ rtl/imu_still_window_offset.sv @@
`timescale 1ns / 1ps
`default_nettype none

// IMU stillness detector with offset capture.
//
// Input stream s_*: one six-axis sample per word. Output stream m_*: one
// result word per window evaluation, carrying the still flag in m_tuser and
// the held offsets in m_tdata; pready is always high. The user must write
// the APB configuration only while the block is idle; it is not enforced.
//
// Words that do not close an evaluation pass through the queue into the
// window memory. An evaluating word scans the window memory one entry per
// cycle through its single read port, then runs the spread test and, when
// still, divides the lane sums by reciprocal multiplication, one lane per
// cycle, before the result is loaded; when not still, the division is
// skipped.
//
// A two-word queue sits between the accepting front and the evaluating back,
// and the result register holds a finished word, so samples are still taken
// while the receiver stalls until the queue fills. Reset empties the queue,
// clears the fill count, the write pointer and the held offsets, and sets
// spread_limit to 20 and batch mode.
module imu_still_window_offset #(
  parameter int WINDOW = imu_swo_pkg::WINDOW_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  input  wire logic [imu_swo_pkg::DATA_W-1:0]      s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // accel_offset_x, accel_offset_y, accel_offset_z,
  // gyro_offset_x, gyro_offset_y, gyro_offset_z
  output logic [imu_swo_pkg::DATA_W-1:0]           m_tdata,
  // still
  output logic [0:0]                               m_tuser,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [imu_swo_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [imu_swo_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [imu_swo_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                     pready
);
  import imu_swo_pkg::*;

  logic        sliding_mode;
  logic [7:0]  spread_limit;
  logic        cfg_wr;
  logic        cfg_sel;
  logic        q_valid;
  logic        q_ready;
  job_t        q_job;
  logic        m_still;
  axes_t       m_offsets;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = paddr[2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sliding_mode <= 1'b0;
      spread_limit <= SPREAD_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_SLIDING: sliding_mode <= pwdata[0];
        REG_SPREAD:  spread_limit <= pwdata[7:0];
        default:     ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_sel)
      REG_SLIDING: prdata = {{(CFG_DATA_W-1){1'b0}}, sliding_mode};
      REG_SPREAD:  prdata = {{(CFG_DATA_W-8){1'b0}}, spread_limit};
      default:     prdata = '0;
    endcase
  end

  imu_swo_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sliding_mode (sliding_mode),
    .s_valid      (s_tvalid),
    .s_ready      (s_tready),
    .s_sample     (axes_t'(s_tdata)),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_job        (q_job)
  );

  imu_swo_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .spread_limit (spread_limit),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_job        (q_job),
    .m_valid      (m_tvalid),
    .m_ready      (m_tready),
    .m_still      (m_still),
    .m_offsets    (m_offsets)
  );

  assign m_tdata    = m_offsets;
  assign m_tuser[0] = m_still;

endmodule

`default_nettype wire

@@ rtl/imu_swo_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module imu_swo_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_tready,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [imu_swo_pkg::DATA_W-1:0]      m_tdata,
  input wire logic [0:0]                          m_tuser,
  input wire logic [imu_swo_pkg::CFG_ADDR_W-1:0]  paddr,
  input wire logic [imu_swo_pkg::CFG_DATA_W-1:0]  prdata,
  input wire logic                                pready
);
  import imu_swo_pkg::*;

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // After reset the queue is empty and no result is pending.
  a_reset_state: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("queue or result register not cleared by reset");

  // The configuration port never inserts wait states.
  a_no_wait: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("configuration port inserted a wait state");

  // Read-back carries only the bits of each register.
  a_readback_width: assert property (@(posedge clk) disable iff (rst)
    pready && (paddr[2] ? (prdata[CFG_DATA_W-1:8] == '0) : (prdata[CFG_DATA_W-1:1] == '0)))
    else $error("register read-back has stray bits");

endmodule

bind imu_still_window_offset imu_swo_checker u_imu_swo_checker (.*);

`default_nettype wire
